// ===== hdl/sdf_pkg.sv =====
// Shared types and constants of the substring delete filter.
package sdf_pkg;

   // Pattern storage is fixed by the two 64-bit pattern registers.
   localparam int PAT_BYTES = 16;
   localparam int LEN_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 64;

   // Register indexes of the write port.
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HIGH = 2'd2;

   // One queued request.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_type;

   // Back end sequencer.
   typedef enum logic [1:0] {
      ST_TAKE  = 2'b01,
      ST_DRAIN = 2'b10
   } back_state_type;

endpackage

// ===== hdl/sdf_front.sv =====
// Front end: accepts requests and holds them in a two-entry queue.
module sdf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_in_last,
   output logic             item_valid,
   output sdf_pkg::req_type item,
   input  logic             item_ready
);

   sdf_pkg::req_type ent_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   assign req_ready  = (fill_ff != 2'd2);
   assign item_valid = (fill_ff != 2'd0);
   assign item       = ent_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff].data <= req_in_byte;
         ent_ff[wr_ptr_ff].last <= req_in_last;
      end
   end

`ifndef SYNTH
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3) else $error("queue fill out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fill_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> fill_ff == $past(fill_ff) + 2'd1) else $error("fill lost a push");
`endif

endmodule

// ===== hdl/sdf_back.sv =====
// Back end: pending-byte window, pattern match and result register.
module sdf_back #(
   parameter int WIN_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  sdf_pkg::req_type             item,
   output logic                         item_ready,
   input  logic [sdf_pkg::LEN_W-1:0]    pat_len,
   input  logic [8*sdf_pkg::PAT_BYTES-1:0] pattern,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_has_byte,
   output logic                         rsp_out_last
);

   localparam int CNT_W = $clog2(WIN_DEPTH + 1);
   localparam int IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

   // Window is newest-aligned: entry 0 is the newest byte.
   logic [7:0]              win_ff [WIN_DEPTH];
   logic [7:0]              win_in [WIN_DEPTH];
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic                    last_ff, last_in;
   sdf_pkg::back_state_type state_ff, state_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic                    rsp_has_ff, rsp_has_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_load;

   logic [7:0]              pat_b [sdf_pkg::PAT_BYTES];
   logic [7:0]              pat_al [WIN_DEPTH];
   logic [CNT_W-1:0]        eff_len;
   logic [CNT_W-1:0]        app_cnt;
   logic [CNT_W-1:0]        base_n, emit_n, kept;
   logic                    pat_hit, tail_full;
   logic [IDX_W-1:0]        rd_idx;
   logic [7:0]              rd_byte, oldest;
   logic                    out_free, take;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign item_ready = (state_ff == sdf_pkg::ST_TAKE) && out_free;
   assign take       = item_valid && item_ready;

   // Effective length, clipped to window depth.
   always_comb begin
      if (pat_len > sdf_pkg::LEN_W'(WIN_DEPTH)) begin
         eff_len = CNT_W'(WIN_DEPTH);
      end else begin
         eff_len = CNT_W'(pat_len);
      end
   end

   // Pattern reversed so that it lines up with the newest-aligned window.
   always_comb begin
      for (int i = 0; i < sdf_pkg::PAT_BYTES; i++) begin
         pat_b[i] = pattern[8*i +: 8];
      end
      for (int j = 0; j < WIN_DEPTH; j++) begin
         pat_al[j] = pat_b[4'(int'(eff_len) - 1 - j)];
      end
   end

   // Window with the request byte appended.
   always_comb begin
      win_in[0] = item.data;
      for (int j = 1; j < WIN_DEPTH; j++) begin
         win_in[j] = win_ff[j-1];
      end
   end

   assign app_cnt = cnt_ff + CNT_W'(1);

   // Tail match: the newest eff_len bytes equal the pattern.
   always_comb begin
      pat_hit = 1'b1;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         if (j < int'(eff_len) && win_in[j] != pat_al[j]) begin
            pat_hit = 1'b0;
         end
      end
      tail_full = (eff_len != '0) && (app_cnt >= eff_len);
      pat_hit   = pat_hit && tail_full;
   end

   // Number of bytes leaving the front of the window for this request.
   always_comb begin
      base_n = (app_cnt > eff_len) ? (app_cnt - eff_len) : '0;
      if (item.last) begin
         emit_n = pat_hit ? base_n : app_cnt;
      end else begin
         emit_n = base_n + CNT_W'(tail_full && !pat_hit);
      end
      kept = (item.last || pat_hit) ? '0 : (app_cnt - emit_n);
   end

   // Single variable read port on the window.
   assign rd_idx  = (state_ff == sdf_pkg::ST_DRAIN) ? ptr_ff : IDX_W'(cnt_ff - CNT_W'(1));
   assign rd_byte = win_ff[rd_idx];
   assign oldest  = (cnt_ff == '0) ? item.data : rd_byte;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      rsp_load     = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         sdf_pkg::ST_TAKE: begin
            if (take) begin
               cnt_in = kept;
               if (emit_n != '0) begin
                  rsp_load    = 1'b1;
                  rsp_byte_in = oldest;
                  rsp_has_in  = 1'b1;
                  rsp_last_in = item.last && (emit_n == CNT_W'(1));
               end else if (item.last) begin
                  rsp_load    = 1'b1;
                  rsp_byte_in = 8'd0;
                  rsp_has_in  = 1'b0;
                  rsp_last_in = 1'b1;
               end
               if (emit_n > CNT_W'(1)) begin
                  state_in = sdf_pkg::ST_DRAIN;
                  ptr_in   = IDX_W'(app_cnt - CNT_W'(2));
                  rem_in   = emit_n - CNT_W'(1);
                  last_in  = item.last;
               end
            end
         end
         sdf_pkg::ST_DRAIN: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_byte_in = rd_byte;
               rsp_has_in  = 1'b1;
               rsp_last_in = last_ff && (rem_ff == CNT_W'(1));
               ptr_in      = ptr_ff - IDX_W'(1);
               rem_in      = rem_ff - CNT_W'(1);
               if (rem_ff == CNT_W'(1)) begin
                  state_in = sdf_pkg::ST_TAKE;
               end
            end
         end
         default: begin
            state_in = sdf_pkg::ST_TAKE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdf_pkg::ST_TAKE;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      last_ff     <= last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
      if (take) begin
         win_ff <= win_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_has_byte = rsp_has_ff;
   assign rsp_out_last = rsp_last_ff;

`ifndef SYNTH
   a_cnt_room: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(WIN_DEPTH)) else $error("window count reached depth at rest");
   a_drain_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == sdf_pkg::ST_DRAIN |-> rem_ff != '0) else $error("drain with nothing left");
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == sdf_pkg::ST_DRAIN && out_free && rem_ff == CNT_W'(1)
      |=> rsp_last_ff == $past(last_ff) && rsp_valid_ff)
      else $error("drain end lost the last flag");
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(cnt_ff)) else $error("window count moved without a request");
`endif

endmodule

// ===== hdl/substring_delete_filter.sv =====
// Top level of the substring delete filter.
//
// Deletes every non-overlapping occurrence of a pattern of up to 16 bytes from
// a byte stream, scanning left to right; an occurrence formed by joining the
// bytes around a deleted match is kept. Requests carry one byte and a last
// flag; each result carries a kept byte, a has_byte flag (zero for a bare end
// marker) and a last flag set on the final result of the string. A pattern
// length of zero passes every byte through. Rate: one request per cycle
// sustained, with the result path giving one result per cycle. A request
// that causes more than one result (end-of-string flush, or a shortened pattern
// length mid-string) holds the back end until all have left, since they all
// leave through the single result register fed by the window's one read port.
// A two-entry request queue lets the input keep flowing while a result waits
// on rsp_ready. Requests pass the queue register, then the result register.
// Pattern registers must be written through the csr_ port only while the block
// is idle; the block does not enforce it. A write to any other index is dropped.
module substring_delete_filter #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_in_last,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_has_byte,
   output logic                          rsp_out_last,
   // Register write port
   input  logic                          csr_we,
   input  logic [sdf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sdf_pkg::CSR_W-1:0]     csr_wdata
);

   // Window depth: the pattern can never be longer than the stored bytes.
   localparam int WIN_DEPTH = (MAX_PATTERN < sdf_pkg::PAT_BYTES) ?
                              MAX_PATTERN : sdf_pkg::PAT_BYTES;

   logic [sdf_pkg::LEN_W-1:0] pat_len_ff;
   logic [sdf_pkg::CSR_W-1:0] pat_low_ff;
   logic [sdf_pkg::CSR_W-1:0] pat_high_ff;

   logic                      item_valid;
   logic                      item_ready;
   sdf_pkg::req_type          item;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= '0;
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sdf_pkg::CSR_PAT_LEN:  pat_len_ff  <= csr_wdata[sdf_pkg::LEN_W-1:0];
            sdf_pkg::CSR_PAT_LOW:  pat_low_ff  <= csr_wdata;
            sdf_pkg::CSR_PAT_HIGH: pat_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Front: request queue
   sdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in_byte(req_in_byte),
      .req_in_last(req_in_last),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   // Back: window, match and result register
   sdf_back #(
      .WIN_DEPTH(WIN_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_ready  (item_ready),
      .pat_len     (pat_len_ff),
      .pattern     ({pat_high_ff, pat_low_ff}),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_has_byte(rsp_has_byte),
      .rsp_out_last(rsp_out_last)
   );

endmodule
